// ===== hdl/tts_pkg.sv =====
// Shared types and constants for the template tag segmenter.
// No dependencies; every other file of the block uses this package.
package tts_pkg;

    // Default internal counter widths, handed down from the top level.
    localparam int OFFSET_BITS_DEF = 32;
    localparam int LINE_BITS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;

    // Fixed widths of the result fields.
    localparam int OUT_OFFSET_W = 32;
    localparam int OUT_LINE_W   = 20;
    localparam int OUT_COLUMN_W = 16;

    // Segment kinds as they appear on the result port.
    typedef enum logic [2:0] {
        KIND_LITERAL    = 3'd0,
        KIND_DIRECTIVE  = 3'd1,
        KIND_EXPRESSION = 3'd2,
        KIND_STATEMENT  = 3'd3,
        KIND_COMMENT    = 3'd4
    } t_kind;

    // Tag classification progress.
    typedef enum logic [2:0] {
        PH_AWAIT      = 3'd0,
        PH_DASH       = 3'd1,
        PH_DIRECTIVE  = 3'd2,
        PH_EXPRESSION = 3'd3,
        PH_STATEMENT  = 3'd4,
        PH_COMMENT    = 3'd5
    } t_phase;

    // One segment record.
    typedef struct packed {
        t_kind                     kind;
        logic                      unterminated;
        logic [OUT_OFFSET_W-1:0]   start_offset;
        logic [OUT_OFFSET_W-1:0]   segment_length;
        logic [OUT_LINE_W-1:0]     start_line;
        logic [OUT_COLUMN_W-1:0]   start_column;
        logic                      last_of_run;
    } t_result;

    // Which of the two record slots are written into the result queue.
    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

// ===== hdl/template_tag_segmenter.sv =====
// Path: input register, then parse step writing into the result queue. Throughput: one
// byte per cycle while the queue has room for two records; a byte that yields two records
// (a literal and an unterminated-tag error) has both handed out in turn by the four-entry
// result queue. Reset (i_rst_n low, synchronous) empties the input register and the queue
// and returns the parse state to the start of a text.
//
// Structure: tts_core holds the input register and the per-byte parse step, which updates
// the position counters, the tag state and the classification phase together and
// writes the resulting records into tts_rqueue. The queue parts the input side from the
// result side, so a stalled result does not hold up parsing until the queue holds more
// than two records, and the input stall is driven only from registered state.
// End of text returns every counter to its reset value, so the next byte starts a new text.
module template_tag_segmenter #(
    parameter int OFFSET_BITS = tts_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = tts_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = tts_pkg::COLUMN_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request channel of text bytes.
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_end_of_text,
    // Request channel of segment records.
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_segment_kind,
    output logic                              o_unterminated,
    output logic [tts_pkg::OUT_OFFSET_W-1:0]  o_start_offset,
    output logic [tts_pkg::OUT_OFFSET_W-1:0]  o_segment_length,
    output logic [tts_pkg::OUT_LINE_W-1:0]    o_start_line,
    output logic [tts_pkg::OUT_COLUMN_W-1:0]  o_start_column,
    output logic                              o_last_of_run
);

    tts_pkg::t_push   push;
    tts_pkg::t_result rec0, rec1, result;
    logic             room;

    // Parse step: one text byte per cycle whenever the queue has room for two records.
    tts_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_stall       (o_stall),
        .i_room        (room),
        .o_push        (push),
        .o_rec0        (rec0),
        .o_rec1        (rec1)
    );

    // Result queue: records leave in produced order, one per cycle while not stalled.
    tts_rqueue u_rqueue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec0   (rec0),
        .i_rec1   (rec1),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (result)
    );

    // The record fields go out on separate ports.
    assign o_segment_kind   = result.kind;
    assign o_unterminated   = result.unterminated;
    assign o_start_offset   = result.start_offset;
    assign o_segment_length = result.segment_length;
    assign o_start_line     = result.start_line;
    assign o_start_column   = result.start_column;
    assign o_last_of_run    = result.last_of_run;

endmodule

// ===== hdl/tts_core.sv =====
// Input register and per-byte parse step of the template tag segmenter.
// Depends on tts_pkg; feeds up to two records per byte to tts_rqueue.
module tts_core #(
    parameter int OFFSET_BITS = tts_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = tts_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = tts_pkg::COLUMN_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_text,
    output logic             o_stall,
    input  logic             i_room,
    output tts_pkg::t_push   o_push,
    output tts_pkg::t_result o_rec0,
    output tts_pkg::t_result o_rec1
);

    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_WS_LO   = 8'h09;
    localparam logic [7:0] CH_WS_HI   = 8'h0D;

    localparam int OW = (OFFSET_BITS > tts_pkg::OUT_OFFSET_W) ? OFFSET_BITS
                                                              : tts_pkg::OUT_OFFSET_W;
    localparam int LW = (LINE_BITS > tts_pkg::OUT_LINE_W) ? LINE_BITS : tts_pkg::OUT_LINE_W;
    localparam int CW = (COLUMN_BITS > tts_pkg::OUT_COLUMN_W) ? COLUMN_BITS
                                                              : tts_pkg::OUT_COLUMN_W;

    function automatic logic [tts_pkg::OUT_OFFSET_W-1:0] off_out(
        input logic [OFFSET_BITS-1:0] v);
        logic [OW-1:0] w;
        w = OW'(v);
        return w[tts_pkg::OUT_OFFSET_W-1:0];
    endfunction

    function automatic logic [tts_pkg::OUT_LINE_W-1:0] line_out(
        input logic [LINE_BITS-1:0] v);
        logic [LW-1:0] w;
        w = LW'(v);
        return w[tts_pkg::OUT_LINE_W-1:0];
    endfunction

    function automatic logic [tts_pkg::OUT_COLUMN_W-1:0] col_out(
        input logic [COLUMN_BITS-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        return w[tts_pkg::OUT_COLUMN_W-1:0];
    endfunction

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_eot;
    logic       fire;

    // Parse state.
    logic                   r_inside, r_pend_open, r_pend_close;
    tts_pkg::t_phase        r_phase;
    logic [OFFSET_BITS-1:0] r_pos, r_seg_start, r_lt_off;
    logic [LINE_BITS-1:0]   r_line, r_seg_line, r_lt_line;
    logic [COLUMN_BITS-1:0] r_col, r_seg_col, r_lt_col;

    // Next values after one byte, before the end-of-text return to reset.
    logic                   n_inside, n_pend_open, n_pend_close;
    tts_pkg::t_phase        n_phase;
    logic [OFFSET_BITS-1:0] n_pos, n_seg_start, n_lt_off;
    logic [LINE_BITS-1:0]   n_line, n_seg_line, n_lt_line;
    logic [COLUMN_BITS-1:0] n_col, n_seg_col, n_lt_col;

    logic            is_ws;
    logic            lit_emit, tag_emit, end_emit;
    tts_pkg::t_kind  tag_kind;
    tts_pkg::t_result lit_rec, tag_rec, end_rec;

    assign fire    = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;
    assign is_ws   = (r_byte == CH_SPACE) || ((r_byte >= CH_WS_LO) && (r_byte <= CH_WS_HI));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_byte <= i_data_byte;
            r_eot  <= i_end_of_text;
        end
    end

    // Next-state logic.
    always_comb begin
        n_inside     = r_inside;
        n_pend_open  = r_pend_open;
        n_pend_close = r_pend_close;
        n_phase      = r_phase;
        n_seg_start  = r_seg_start;
        n_seg_line   = r_seg_line;
        n_seg_col    = r_seg_col;
        n_lt_off     = r_lt_off;
        n_lt_line    = r_lt_line;
        n_lt_col     = r_lt_col;

        n_pos = (r_pos == '1) ? r_pos : r_pos + 1'b1;
        if (r_byte == CH_NL) begin
            n_line = (r_line == '1) ? r_line : r_line + 1'b1;
            n_col  = COLUMN_BITS'(1);
        end else begin
            n_line = r_line;
            n_col  = (r_col == '1) ? r_col : r_col + 1'b1;
        end

        if (!r_inside) begin
            if (r_pend_open && (r_byte == CH_PCT)) begin
                n_inside     = 1'b1;
                n_pend_open  = 1'b0;
                n_pend_close = 1'b0;
                n_phase      = tts_pkg::PH_AWAIT;
                n_seg_start  = r_lt_off;
                n_seg_line   = r_lt_line;
                n_seg_col    = r_lt_col;
            end else if (r_byte == CH_LT) begin
                n_pend_open = 1'b1;
                n_lt_off    = r_pos;
                n_lt_line   = r_line;
                n_lt_col    = r_col;
            end else begin
                n_pend_open = 1'b0;
            end
        end else if (r_pend_close && (r_byte == CH_GT)) begin
            n_inside     = 1'b0;
            n_pend_close = 1'b0;
            n_phase      = tts_pkg::PH_AWAIT;
            n_seg_start  = n_pos;
            n_seg_line   = n_line;
            n_seg_col    = n_col;
        end else begin
            n_pend_close = (r_byte == CH_PCT);
            priority case (r_phase)
                tts_pkg::PH_AWAIT: begin
                    if (!is_ws) begin
                        priority if (r_byte == CH_DASH) n_phase = tts_pkg::PH_DASH;
                        else if (r_byte == CH_AT)       n_phase = tts_pkg::PH_DIRECTIVE;
                        else if (r_byte == CH_EQ)       n_phase = tts_pkg::PH_EXPRESSION;
                        else                            n_phase = tts_pkg::PH_STATEMENT;
                    end
                end
                tts_pkg::PH_DASH: begin
                    n_phase = (r_byte == CH_DASH) ? tts_pkg::PH_COMMENT
                                                  : tts_pkg::PH_STATEMENT;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_eot)) begin
            r_inside     <= 1'b0;
            r_pend_open  <= 1'b0;
            r_pend_close <= 1'b0;
            r_phase      <= tts_pkg::PH_AWAIT;
            r_pos        <= '0;
            r_line       <= LINE_BITS'(1);
            r_col        <= COLUMN_BITS'(1);
            r_seg_start  <= '0;
            r_seg_line   <= LINE_BITS'(1);
            r_seg_col    <= COLUMN_BITS'(1);
            r_lt_off     <= '0;
            r_lt_line    <= LINE_BITS'(1);
            r_lt_col     <= COLUMN_BITS'(1);
        end else if (fire) begin
            r_inside     <= n_inside;
            r_pend_open  <= n_pend_open;
            r_pend_close <= n_pend_close;
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_line       <= n_line;
            r_col        <= n_col;
            r_seg_start  <= n_seg_start;
            r_seg_line   <= n_seg_line;
            r_seg_col    <= n_seg_col;
            r_lt_off     <= n_lt_off;
            r_lt_line    <= n_lt_line;
            r_lt_col     <= n_lt_col;
        end
    end

    // Record outputs.
    always_comb begin
        lit_emit = !r_inside && r_pend_open && (r_byte == CH_PCT) && (r_lt_off > r_seg_start);
        tag_emit = r_inside && r_pend_close && (r_byte == CH_GT);
        end_emit = r_eot && (n_inside || (n_pos > n_seg_start));

        unique case (r_phase)
            tts_pkg::PH_DIRECTIVE:  tag_kind = tts_pkg::KIND_DIRECTIVE;
            tts_pkg::PH_EXPRESSION: tag_kind = tts_pkg::KIND_EXPRESSION;
            tts_pkg::PH_COMMENT:    tag_kind = tts_pkg::KIND_COMMENT;
            default:                tag_kind = tts_pkg::KIND_STATEMENT;
        endcase

        lit_rec.kind           = tts_pkg::KIND_LITERAL;
        lit_rec.unterminated   = 1'b0;
        lit_rec.start_offset   = off_out(r_seg_start);
        lit_rec.segment_length = off_out(r_lt_off - r_seg_start);
        lit_rec.start_line     = line_out(r_seg_line);
        lit_rec.start_column   = col_out(r_seg_col);
        lit_rec.last_of_run    = !end_emit;

        tag_rec.kind           = tag_kind;
        tag_rec.unterminated   = 1'b0;
        tag_rec.start_offset   = off_out(r_seg_start);
        tag_rec.segment_length = off_out(n_pos - r_seg_start);
        tag_rec.start_line     = line_out(r_seg_line);
        tag_rec.start_column   = col_out(r_seg_col);
        tag_rec.last_of_run    = !end_emit;

        end_rec.kind           = tts_pkg::KIND_LITERAL;
        end_rec.unterminated   = n_inside;
        end_rec.start_offset   = off_out(n_seg_start);
        end_rec.segment_length = off_out(n_pos - n_seg_start);
        end_rec.start_line     = line_out(n_seg_line);
        end_rec.start_column   = col_out(n_seg_col);
        end_rec.last_of_run    = 1'b1;

        o_rec1 = end_rec;
        if (lit_emit) begin
            o_rec0        = lit_rec;
            o_push.first  = fire;
            o_push.second = fire && end_emit;
        end else if (tag_emit) begin
            o_rec0        = tag_rec;
            o_push.first  = fire;
            o_push.second = fire && end_emit;
        end else begin
            o_rec0        = end_rec;
            o_push.first  = fire && end_emit;
            o_push.second = 1'b0;
        end
    end

endmodule

// ===== hdl/tts_rqueue.sv =====
// Four-entry result queue of the template tag segmenter.
// Depends on tts_pkg; takes up to two records a cycle and delivers one unless stalled.
module tts_rqueue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tts_pkg::t_push   i_push,
    input  tts_pkg::t_result i_rec0,
    input  tts_pkg::t_result i_rec1,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_stall,
    output tts_pkg::t_result o_result
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tts_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [PTR_W-1:0] wr_next;
    logic             pop;

    assign o_valid  = (r_count != '0);
    assign o_room   = (r_count <= CNT_W'(DEPTH - 2));
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid && !i_stall;
    assign wr_next  = r_wr + 1'b1;
    assign n_count  = r_count + CNT_W'(i_push.first) + CNT_W'(i_push.second)
                      - CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push.first) + PTR_W'(i_push.second);
            r_rd    <= r_rd + PTR_W'(pop);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr] <= i_rec0;
        end
        if (i_push.second) begin
            r_mem[wr_next] <= i_rec1;
        end
    end

endmodule

// ===== hdl/tts_checker.sv =====
// Port-level checks for the template tag segmenter, attached by a bind.
// Depends on tts_pkg and on the top level's port list.
module tts_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [2:0]                        o_segment_kind,
    input logic                              o_unterminated,
    input logic [tts_pkg::OUT_OFFSET_W-1:0]  o_start_offset,
    input logic [tts_pkg::OUT_OFFSET_W-1:0]  o_segment_length,
    input logic [tts_pkg::OUT_LINE_W-1:0]    o_start_line,
    input logic [tts_pkg::OUT_COLUMN_W-1:0]  o_start_column,
    input logic                              o_last_of_run
);

    // A stalled record stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_segment_kind) && $stable(o_unterminated)
            && $stable(o_start_offset) && $stable(o_segment_length)
            && $stable(o_start_line) && $stable(o_start_column) && $stable(o_last_of_run))
        else $error("stalled record changed");

    // Only the five defined kinds are ever produced.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_segment_kind <= tts_pkg::KIND_COMMENT))
        else $error("undefined segment kind");

    // An unterminated-tag error is a literal-kind record and always closes its run.
    a_unterm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_unterminated |->
            o_last_of_run && (o_segment_kind == tts_pkg::KIND_LITERAL))
        else $error("unterminated record malformed");

    // Nothing is offered right after reset.
    a_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("record offered after reset");

endmodule

bind template_tag_segmenter tts_checker u_tts_checker (.*);

// ===== tb/template_tag_segmenter_test.sv =====
// Self-checking testbench for template_tag_segmenter: a byte-level predictor of the
// tag splitter feeds a queue of expected segment records. Depends on tts_pkg and the RTL.
`timescale 1ns / 1ps

// Bytes that steer the tag parser.
localparam logic [7:0] CH_LT      = 8'h3C;
localparam logic [7:0] CH_PCT     = 8'h25;
localparam logic [7:0] CH_GT      = 8'h3E;
localparam logic [7:0] CH_DASH    = 8'h2D;
localparam logic [7:0] CH_AT      = 8'h40;
localparam logic [7:0] CH_EQ      = 8'h3D;
localparam logic [7:0] CH_NEWLINE = 8'h0A;
localparam logic [7:0] CH_SPACE   = 8'h20;
localparam logic [7:0] CH_TAB     = 8'h09;

// Tracks the parse of the text byte by byte and holds the segment records that the
// block still owes, oldest first.
class segment_checker;
    logic [31:0]      next_offset;
    logic [19:0]      next_line;
    logic [15:0]      next_column;
    logic [31:0]      seg_offset;
    logic [19:0]      seg_line;
    logic [15:0]      seg_column;
    logic [31:0]      lt_offset;
    logic [19:0]      lt_line;
    logic [15:0]      lt_column;
    bit               in_tag;
    bit               after_lt;
    bit               after_pct;
    tts_pkg::t_phase  phase;
    tts_pkg::t_result awaited[$];
    int               errors;

    function new();
        errors = 0;
        start_text();
    endfunction

    function void start_text();
        next_offset = '0;
        next_line   = 20'd1;
        next_column = 16'd1;
        seg_offset  = '0;
        seg_line    = 20'd1;
        seg_column  = 16'd1;
        lt_offset   = '0;
        lt_line     = 20'd1;
        lt_column   = 16'd1;
        in_tag      = 1'b0;
        after_lt    = 1'b0;
        after_pct   = 1'b0;
        phase       = tts_pkg::PH_AWAIT;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function bit is_space(logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= 8'h0D);
    endfunction

    function tts_pkg::t_result make_record(tts_pkg::t_kind k, logic unterm,
                                           logic [31:0] len);
        tts_pkg::t_result r;
        r.kind           = k;
        r.unterminated   = unterm;
        r.start_offset   = seg_offset;
        r.segment_length = len;
        r.start_line     = seg_line;
        r.start_column   = seg_column;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    // Advances the parse by one accepted byte and queues the records it completes.
    function void note_byte(logic [7:0] b, logic last);
        logic [31:0]      here_offset;
        logic [19:0]      here_line;
        logic [15:0]      here_column;
        tts_pkg::t_result recs[2];
        int               n;
        tts_pkg::t_kind   k;
        here_offset = next_offset;
        here_line   = next_line;
        here_column = next_column;
        n = 0;

        if (next_offset != '1) next_offset = next_offset + 32'd1;
        if (b == CH_NEWLINE) begin
            if (next_line != '1) next_line = next_line + 20'd1;
            next_column = 16'd1;
        end else if (next_column != '1) begin
            next_column = next_column + 16'd1;
        end

        if (!in_tag) begin
            if (after_lt && b == CH_PCT) begin
                if (lt_offset > seg_offset) begin
                    recs[n] = make_record(tts_pkg::KIND_LITERAL, 1'b0,
                                          lt_offset - seg_offset);
                    n++;
                end
                in_tag     = 1'b1;
                after_lt   = 1'b0;
                after_pct  = 1'b0;
                phase      = tts_pkg::PH_AWAIT;
                seg_offset = lt_offset;
                seg_line   = lt_line;
                seg_column = lt_column;
            end else if (b == CH_LT) begin
                after_lt  = 1'b1;
                lt_offset = here_offset;
                lt_line   = here_line;
                lt_column = here_column;
            end else begin
                after_lt = 1'b0;
            end
        end else if (after_pct && b == CH_GT) begin
            case (phase)
                tts_pkg::PH_DIRECTIVE:  k = tts_pkg::KIND_DIRECTIVE;
                tts_pkg::PH_EXPRESSION: k = tts_pkg::KIND_EXPRESSION;
                tts_pkg::PH_COMMENT:    k = tts_pkg::KIND_COMMENT;
                default:                k = tts_pkg::KIND_STATEMENT;
            endcase
            recs[n] = make_record(k, 1'b0, next_offset - seg_offset);
            n++;
            in_tag     = 1'b0;
            after_pct  = 1'b0;
            phase      = tts_pkg::PH_AWAIT;
            seg_offset = next_offset;
            seg_line   = next_line;
            seg_column = next_column;
        end else begin
            case (phase)
                tts_pkg::PH_AWAIT: begin
                    if (!is_space(b)) begin
                        if (b == CH_DASH)    phase = tts_pkg::PH_DASH;
                        else if (b == CH_AT) phase = tts_pkg::PH_DIRECTIVE;
                        else if (b == CH_EQ) phase = tts_pkg::PH_EXPRESSION;
                        else                 phase = tts_pkg::PH_STATEMENT;
                    end
                end
                tts_pkg::PH_DASH: phase = (b == CH_DASH) ? tts_pkg::PH_COMMENT
                                                         : tts_pkg::PH_STATEMENT;
                default: ;
            endcase
            after_pct = (b == CH_PCT);
        end

        if (last) begin
            if (in_tag) begin
                recs[n] = make_record(tts_pkg::KIND_LITERAL, 1'b1, next_offset - seg_offset);
                n++;
            end else if (next_offset > seg_offset) begin
                recs[n] = make_record(tts_pkg::KIND_LITERAL, 1'b0, next_offset - seg_offset);
                n++;
            end
            start_text();
        end

        if (n > 0) recs[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++) awaited.push_back(recs[i]);
    endfunction

    function void check_segment(tts_pkg::t_result got);
        tts_pkg::t_result want;
        if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected record: k=%0d u=%0b off=%0d len=%0d ln=%0d col=%0d",
                         got.kind, got.unterminated, got.start_offset, got.segment_length,
                         got.start_line, got.start_column);
            return;
        end
        want = awaited.pop_front();
        if (got.kind !== want.kind || got.unterminated !== want.unterminated ||
            got.start_offset !== want.start_offset ||
            got.segment_length !== want.segment_length ||
            got.start_line !== want.start_line || got.start_column !== want.start_column ||
            got.last_of_run !== want.last_of_run) begin
            errors++;
            if (errors <= 10) begin
                $display("expected: k=%0d u=%0b off=%0d len=%0d ln=%0d col=%0d last=%0b",
                         want.kind, want.unterminated, want.start_offset,
                         want.segment_length, want.start_line, want.start_column,
                         want.last_of_run);
                $display("actual:   k=%0d u=%0b off=%0d len=%0d ln=%0d col=%0d last=%0b",
                         got.kind, got.unterminated, got.start_offset,
                         got.segment_length, got.start_line, got.start_column,
                         got.last_of_run);
            end
        end
    endfunction
endclass

module template_tag_segmenter_test;

    // Timeout, trailing wait after the last record, the long receiver hold-off, the
    // stretch sent with no idling, and the random texts.
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 150;
    localparam int          NO_IDLE_BYTES = 100;
    localparam int          RANDOM_BYTES  = 520;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_data_byte   = 8'h00;
    logic        i_end_of_text = 1'b0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_segment_kind;
    logic        o_unterminated;
    logic [31:0] o_start_offset;
    logic [31:0] o_segment_length;
    logic [19:0] o_start_line;
    logic [15:0] o_start_column;
    logic        o_last_of_run;

    // Stall control. The main process asks for a hold-off by bumping holds_asked; the
    // receiver process alone counts the hold-off down.
    bit          tx_idle_on    = 1'b1;
    bit          rx_idle_on    = 1'b1;
    int          holds_asked   = 0;
    int          holds_granted = 0;
    int          hold_left     = 0;
    int unsigned cycle_count   = 0;

    logic [7:0]      text_buf[$];
    segment_checker  sb;

    template_tag_segmenter uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_text    (i_end_of_text),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_segment_kind   (o_segment_kind),
        .o_unterminated   (o_unterminated),
        .o_start_offset   (o_start_offset),
        .o_segment_length (o_segment_length),
        .o_start_line     (o_start_line),
        .o_start_column   (o_start_column),
        .o_last_of_run    (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a run that hangs ends here as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[template_tag_segmenter] ERROR");
            $finish;
        end
    end

    // Receiver side. Either a long hold-off is running, or one has just been asked for,
    // or the stall is random when idling is enabled.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_granted != holds_asked) begin
            i_stall       <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            holds_granted <= holds_granted + 1;
        end else begin
            i_stall <= rx_idle_on && ($urandom_range(99) < 29);
        end
    end

    // Monitor. Handshakes are judged on the values held just before the edge, so the
    // requests seen here are exactly those the block takes.
    always @(posedge i_clk) begin
        tts_pkg::t_result got;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_byte(i_data_byte, i_end_of_text);
            if (o_valid && !i_stall) begin
                got.kind           = tts_pkg::t_kind'(o_segment_kind);
                got.unterminated   = o_unterminated;
                got.start_offset   = o_start_offset;
                got.segment_length = o_segment_length;
                got.start_line     = o_start_line;
                got.start_column   = o_start_column;
                got.last_of_run    = o_last_of_run;
                sb.check_segment(got);
            end
        end
    end

    // Offers one byte request and returns at the edge that takes it. Valid stays high
    // into the next request unless the sender decides to idle first.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (tx_idle_on && $urandom_range(99) < 29) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_end_of_text <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Sends a string; its final character carries the end-of-text flag.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    // Stops sending and waits for every owed record, then lets the pipeline run dry.
    // The pending count is read on the falling edge, after the monitor has run.
    task automatic settle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? CH_SPACE : CH_TAB + r[7:0];
    endfunction

    // Text characters, weighted so that delimiters and line breaks show up often.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 10) return CH_NEWLINE;
        if (r < 20) return pick_space();
        if (r < 25) return CH_LT;
        if (r < 30) return CH_PCT;
        if (r < 35) return CH_GT;
        if (r < 40) return CH_DASH;
        if (r < 50) return 8'($urandom_range(255));
        return 8'h61 + 8'($urandom_range(25));
    endfunction

    // Opens a tag, gives it a random kind lead-in and body, and closes it if asked.
    task automatic add_tag(input bit closed);
        text_buf.push_back(CH_LT);
        text_buf.push_back(CH_PCT);
        repeat ($urandom_range(2)) text_buf.push_back(pick_space());
        case ($urandom_range(7))
            0: ;
            1: begin
                text_buf.push_back(CH_DASH);
                text_buf.push_back(CH_DASH);
            end
            2: text_buf.push_back(CH_DASH);
            3: text_buf.push_back(CH_AT);
            4: text_buf.push_back(CH_EQ);
            5: text_buf.push_back(CH_PCT);
            default: text_buf.push_back(8'h61 + 8'($urandom_range(25)));
        endcase
        repeat ($urandom_range(5)) text_buf.push_back(pick_char());
        if (closed) begin
            text_buf.push_back(CH_PCT);
            text_buf.push_back(CH_GT);
        end
    endtask

    // Builds one text: mostly literal runs and well-formed tags, sometimes raw noise,
    // tags left open, or a trailing '<'.
    task automatic build_text();
        int r;
        text_buf.delete();
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(12, 1)) text_buf.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(5, 1)) begin
                r = $urandom_range(99);
                if (r < 35)
                    repeat ($urandom_range(8, 1)) text_buf.push_back(pick_char());
                else
                    add_tag(r < 90);
            end
            if ($urandom_range(99) < 8) text_buf.push_back(CH_LT);
        end
    endtask

    initial begin
        int sent;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed texts: single-byte text, every tag kind, whitespace before the kind
        // character, a lone dash, '>' straight after the opener, a trailing '<', a
        // literal and an open-tag error from the same byte, nested openers, and the
        // extreme byte values.
        send_text("a");
        send_text("<%%>");
        send_text("x<%--c%>");
        send_text("<%@ d%>\n");
        send_text(" <% \t=e%>");
        send_text("<%-x%>y");
        send_text("<%>%><");
        send_text("ab<%");
        send_text("<%= x");
        send_text("<<%@%>%>");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();

        // A stretch with no idling on either side, ending in a tag and the literal
        // behind it.
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        for (int i = 0; i < NO_IDLE_BYTES; i++)
            send_byte(8'h61 + 8'($urandom_range(25)), 1'b0);
        send_text("<%=v%>y");
        settle();

        // Back-pressure: the receiver holds off while a burst of tags keeps arriving,
        // so the result queue fills and the input stalls.
        holds_asked <= holds_asked + 1;
        send_text("<%=a%><%@b%><%--c%><%d%>e<%=f%><%@g%><%--h%><%i%>j<%=k%><%l%>");
        settle();
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            build_text();
            send_buffer();
            sent += text_buf.size();
        end
        settle();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[template_tag_segmenter] OK");
        end else begin
            $display("[template_tag_segmenter] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tts_pkg.sv
hdl/tts_core.sv
hdl/tts_rqueue.sv
hdl/template_tag_segmenter.sv
hdl/tts_checker.sv
tb/template_tag_segmenter_test.sv
